### rtl/slc_pkg.sv
`timescale 1ns / 1ps
// Package for the scalar literal coercion block: kind, status and target codes
// and the shared control struct. No dependencies.
package slc_pkg;

    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_INT  = 3'd1;
    localparam logic [2:0] K_UINT = 3'd2;
    localparam logic [2:0] K_BOOL = 3'd3;
    localparam logic [2:0] K_DBL  = 3'd4;

    localparam logic [2:0] S_OK        = 3'd0;
    localparam logic [2:0] S_KIND      = 3'd1;
    localparam logic [2:0] S_OVER      = 3'd2;
    localparam logic [2:0] S_UNDER     = 3'd3;
    localparam logic [2:0] S_LOSS      = 3'd4;
    localparam logic [2:0] S_BOOL      = 3'd5;
    localparam logic [2:0] S_NOTSCALAR = 3'd6;

    localparam logic [3:0] T_ULONG  = 4'd0;
    localparam logic [3:0] T_UINT   = 4'd1;
    localparam logic [3:0] T_USHORT = 4'd2;
    localparam logic [3:0] T_CHAR   = 4'd3;
    localparam logic [3:0] T_UBYTE  = 4'd4;
    localparam logic [3:0] T_LONG   = 4'd5;
    localparam logic [3:0] T_INT    = 4'd6;
    localparam logic [3:0] T_SHORT  = 4'd7;
    localparam logic [3:0] T_BYTE   = 4'd8;
    localparam logic [3:0] T_BOOLT  = 4'd9;
    localparam logic [3:0] T_DOUBLE = 4'd10;
    localparam logic [3:0] T_FLOAT  = 4'd11;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam int          PIPE_DEPTH = 4;

    // Stage-one classification carried alongside the magnitude.
    typedef struct packed {
        logic        done;     // result already known (final kind/bits/status)
        logic [2:0]  kind;
        logic [63:0] bits;
        logic [2:0]  status;
        logic        neg;      // float path: negative integer
        logic        wide;     // float path: 53-bit significand
    } slc_ctl_t;

endpackage

### rtl/scalar_literal_coercion.sv
`timescale 1ns / 1ps
// Top level of the scalar literal coercion block: stream handshake, the
// configuration register and the pipeline. Depends on slc_pkg and slc_core.
//
// Use: a typed literal arrives as one transaction on the s_ channel; tdata
// carries value_kind, value_bits and target_type, lowest bits first. Each
// transaction yields exactly one transaction on the m_ channel with the new
// kind, the converted bits and a status code; on any error the kind and bits
// are zero and the status names the error.
// The accepting edge loads the classify stage, and the transaction then moves
// through the bit count, normalise and output stages before the result is
// offered. While the output is not stalled the pipeline takes a new
// transaction in every cycle, so throughput is one per cycle, as every
// stage holds one transaction and all stages move together.
// When the receiver holds m_axis_tready low while a result is offered, the
// whole pipeline freezes and s_axis_tready is low, even if earlier stages
// are empty; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and clears the
// allow_bool_int_conversion register. cfg_we writes bit 0 of cfg_wdata;
// it must only be written while the block is idle.
module scalar_literal_coercion import slc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // value_kind[2:0], value_bits[66:3], target_type[70:67], zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_kind[2:0], result_bits[66:3], status[69:67], zero pad
    output logic [71:0] m_axis_tdata
);

    logic                  allow_reg;
    logic                  advance;
    logic [PIPE_DEPTH-1:0] valid;
    logic [2:0]            r_kind, r_status;
    logic [63:0]           r_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reg <= 1'b0;
        end else if (cfg_we) begin
            allow_reg <= cfg_wdata;
        end
    end

    // The pipeline moves whenever the output slot is empty or being taken.
    assign advance       = !valid[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = valid[PIPE_DEPTH-1];

    slc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (s_axis_tvalid),
        .allow_conv (allow_reg),
        .in_kind    (s_axis_tdata[2:0]),
        .in_bits    (s_axis_tdata[66:3]),
        .in_target  (s_axis_tdata[70:67]),
        .valid_out  (valid),
        .out_kind   (r_kind),
        .out_bits   (r_bits),
        .out_status (r_status)
    );

    assign m_axis_tdata = {2'b00, r_status, r_bits, r_kind};

endmodule

### rtl/slc_core.sv
`timescale 1ns / 1ps
// Pipelined datapath of the scalar literal coercion block: classification,
// range checks and integer to double conversion over four stages. Uses slc_pkg.
module slc_core import slc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic                  allow_conv,
    input  logic [2:0]            in_kind,
    input  logic [63:0]           in_bits,
    input  logic [3:0]            in_target,
    output logic [PIPE_DEPTH-1:0] valid_out,
    output logic [2:0]            out_kind,
    output logic [63:0]           out_bits,
    output logic [2:0]            out_status
);

    logic [PIPE_DEPTH-1:0] valid_reg;

    // stage 1: classification and magnitude
    slc_ctl_t    c1_next, c1_reg;
    logic [63:0] m1_next, m1_reg;
    // stage 2: leading one and trailing zero counts
    slc_ctl_t    c2_reg;
    logic [63:0] m2_reg;
    logic [5:0]  e2_next, e2_reg, t2_next, t2_reg;
    logic        z2_next, z2_reg;
    // stage 3: precision check and normalising shift
    slc_ctl_t    c3_next, c3_reg;
    // stage 4: output register
    slc_ctl_t    c4_reg;

    always_comb begin
        logic [2:0]  k;
        logic [63:0] v;
        logic [63:0] lim;
        c1_next = '0;
        m1_next = '0;
        k = in_kind;
        v = in_bits;
        lim = '0;
        if (k == K_INT && !v[63]) k = K_UINT;
        if (k == K_BOOL) v = {63'd0, |in_bits};
        if (k == K_BOOL && in_target != T_BOOLT && allow_conv) k = K_UINT;
        c1_next.done = 1'b1;
        if (in_kind == K_NONE) begin
            c1_next.bits = in_bits;
        end else begin
            case (in_target)
                T_ULONG, T_UINT, T_USHORT, T_CHAR, T_UBYTE: begin
                    lim = (in_target == T_ULONG) ? '1 :
                          (in_target == T_UINT) ? 64'hFFFF_FFFF :
                          (in_target == T_USHORT) ? 64'hFFFF : 64'hFF;
                    if (k != K_UINT) c1_next.status = S_KIND;
                    else if (v > lim) c1_next.status = S_OVER;
                    else begin
                        c1_next.kind = K_UINT;
                        c1_next.bits = v;
                    end
                end
                T_LONG, T_INT, T_SHORT, T_BYTE: begin
                    lim = (in_target == T_LONG) ? (SIGN_BIT - 64'd1) :
                          (in_target == T_INT) ? 64'h7FFF_FFFF :
                          (in_target == T_SHORT) ? 64'h7FFF : 64'h7F;
                    if (k == K_INT) begin
                        if ((64'd0 - v) > (lim + 64'd1)) c1_next.status = S_UNDER;
                        else begin
                            c1_next.kind = K_INT;
                            c1_next.bits = v;
                        end
                    end else if (k == K_UINT) begin
                        if (v > lim) c1_next.status = S_OVER;
                        else begin
                            c1_next.kind = K_INT;
                            c1_next.bits = v;
                        end
                    end else c1_next.status = S_KIND;
                end
                T_BOOLT: begin
                    if (k == K_UINT && allow_conv) begin
                        if (v > 64'd1) c1_next.status = S_BOOL;
                        else begin
                            c1_next.kind = K_UINT;
                            c1_next.bits = v;
                        end
                    end else if (k != K_BOOL) c1_next.status = S_KIND;
                    else begin
                        c1_next.kind = K_BOOL;
                        c1_next.bits = v;
                    end
                end
                T_DOUBLE, T_FLOAT: begin
                    c1_next.wide = (in_target == T_DOUBLE);
                    if (k == K_DBL) begin
                        c1_next.kind = K_DBL;
                        c1_next.bits = v;
                    end else if (k == K_INT || k == K_UINT) begin
                        c1_next.done = 1'b0;
                        c1_next.neg = (k == K_INT);
                        m1_next = (k == K_INT) ? (64'd0 - v) : v;
                    end else c1_next.status = S_KIND;
                end
                default: c1_next.status = S_NOTSCALAR;
            endcase
        end
    end

    always_comb begin
        e2_next = '0;
        t2_next = '0;
        for (int i = 0; i < 64; i++) begin
            if (m1_reg[i]) e2_next = 6'(i);
        end
        for (int i = 63; i >= 0; i--) begin
            if (m1_reg[i]) t2_next = 6'(i);
        end
        z2_next = (m1_reg == 64'd0);
    end

    always_comb begin
        logic [6:0]  span;
        logic [63:0] frac;
        logic [10:0] expo;
        c3_next = c2_reg;
        span = 7'(e2_reg) - 7'(t2_reg);
        frac = '0;
        expo = 11'(e2_reg) + 11'd1023;
        if (!c2_reg.done) begin
            c3_next.done = 1'b1;
            if (z2_reg) begin
                c3_next.kind = K_DBL;
                c3_next.bits = '0;
            end else if (span >= (c2_reg.wide ? 7'd53 : 7'd24)) begin
                c3_next.status = S_LOSS;
            end else begin
                frac = (m2_reg << (7'd63 - 7'(e2_reg))) >> 11;
                c3_next.kind = K_DBL;
                c3_next.bits = {c2_reg.neg, expo, frac[51:0]};
            end
        end
        if (c3_next.status != S_OK) begin
            c3_next.kind = K_NONE;
            c3_next.bits = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            c1_reg <= c1_next;
            m1_reg <= m1_next;
            c2_reg <= c1_reg;
            m2_reg <= m1_reg;
            e2_reg <= e2_next;
            t2_reg <= t2_next;
            z2_reg <= z2_next;
            c3_reg <= c3_next;
            c4_reg <= c3_reg;
        end
    end

    assign valid_out  = valid_reg;
    assign out_kind   = c4_reg.kind;
    assign out_bits   = c4_reg.bits;
    assign out_status = c4_reg.status;

endmodule

### rtl/slc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for scalar_literal_coercion, bound to the top level.
// Depends on slc_pkg for the kind and status codes.
module slc_checker import slc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // A pending result is held while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // The input side only waits while the output is stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // An error status always comes with kind none and zero bits.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[69:67] != S_OK
        |-> m_axis_tdata[66:0] == 67'd0)
        else $error("error result carries data");

    // The status code never exceeds the defined range and padding is zero.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[69:67] != 3'd7 && m_axis_tdata[71:70] == 2'd0)
        else $error("bad status or padding");

endmodule

bind scalar_literal_coercion slc_checker u_slc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/scalar_literal_coercion_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the scalar literal coercion block.
// Depends on slc_pkg and the scalar_literal_coercion top level.
module scalar_literal_coercion_tb;
    import slc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // value_kind[2:0], value_bits[66:3], target_type[70:67], zero pad
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result_kind[2:0], result_bits[66:3], status[69:67], zero pad
    logic [71:0] m_axis_tdata;

    // The conversion switch as the bench believes the block holds it.
    logic        conv_en = 1'b0;

    // Literals waiting to be driven, and coerced results still owed.
    logic [71:0] literal_q[$];
    logic [71:0] coerced_q[$];

    int  mismatches = 0;
    bit  quiet = 1'b0;     // no idling on either side near the end
    int  src_gap = 0;
    int  sink_gap = 0;

    always #6 aclk = ~aclk;

    scalar_literal_coercion uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    // Returns 1 when the magnitude fits a significand of the given width
    // once its trailing zeros are stripped.
    function automatic bit exact_in_significand(logic [63:0] mag, int width);
        logic [63:0] m;
        m = mag;
        if (m == 0) return 1'b1;
        while (m[0] == 1'b0) m = m >> 1;
        return (m >> width) == 0;
    endfunction

    // IEEE double encoding of an exactly representable integer.
    function automatic logic [63:0] int_to_double(bit neg, logic [63:0] mag);
        int          msb;
        logic [63:0] frac;
        if (mag == 0) return 64'd0;
        msb = 63;
        while (mag[msb] == 1'b0) msb--;
        if (msb <= 52) frac = mag << (52 - msb);
        else frac = mag >> (msb - 52);
        frac[63:52] = '0;
        return {neg, 11'(1023 + msb), frac[51:0]};
    endfunction

    // Predicts the result word for one literal under the current setting.
    function automatic logic [71:0] coerce(logic [71:0] lit);
        logic [2:0]  kind;
        logic [63:0] v;
        logic [3:0]  tgt;
        logic [2:0]  rk;
        logic [2:0]  st;
        logic [63:0] rb;
        logic [63:0] lim;
        logic [63:0] mag;
        kind = lit[2:0];
        v    = lit[66:3];
        tgt  = lit[70:67];
        rk = K_NONE;
        st = S_OK;
        rb = '0;
        if (kind == K_NONE) return {2'b00, S_OK, v, K_NONE};
        // A non-negative signed literal is handled as unsigned.
        if (kind == K_INT && v[63] == 1'b0) kind = K_UINT;
        if (kind == K_BOOL) v = (v != 0) ? 64'd1 : 64'd0;
        if (kind == K_BOOL && tgt != T_BOOLT && conv_en) kind = K_UINT;
        case (tgt)
            T_ULONG, T_UINT, T_USHORT, T_CHAR, T_UBYTE: begin
                lim = (tgt == T_ULONG) ? 64'hFFFF_FFFF_FFFF_FFFF :
                      (tgt == T_UINT) ? 64'hFFFF_FFFF :
                      (tgt == T_USHORT) ? 64'hFFFF : 64'hFF;
                if (kind != K_UINT) st = S_KIND;
                else if (v > lim) st = S_OVER;
                else begin
                    rk = K_UINT;
                    rb = v;
                end
            end
            T_LONG, T_INT, T_SHORT, T_BYTE: begin
                lim = (tgt == T_LONG) ? SIGN_BIT - 1 :
                      (tgt == T_INT) ? 64'h7FFF_FFFF :
                      (tgt == T_SHORT) ? 64'h7FFF : 64'h7F;
                if (kind == K_INT) begin
                    // Negative values may reach one more than the positive limit.
                    if ((64'd0 - v) > lim + 1) st = S_UNDER;
                    else begin
                        rk = K_INT;
                        rb = v;
                    end
                end else if (kind == K_UINT) begin
                    if (v > lim) st = S_OVER;
                    else begin
                        rk = K_INT;
                        rb = v;
                    end
                end else st = S_KIND;
            end
            T_BOOLT: begin
                if (kind == K_UINT && conv_en) begin
                    if (v > 1) st = S_BOOL;
                    else begin
                        rk = K_UINT;
                        rb = v;
                    end
                end else if (kind != K_BOOL) st = S_KIND;
                else begin
                    rk = K_BOOL;
                    rb = v;
                end
            end
            T_DOUBLE, T_FLOAT: begin
                if (kind == K_DBL) begin
                    rk = K_DBL;
                    rb = v;
                end else if (kind == K_INT || kind == K_UINT) begin
                    mag = (kind == K_INT) ? 64'd0 - v : v;
                    if (!exact_in_significand(mag, (tgt == T_DOUBLE) ? 53 : 24))
                        st = S_LOSS;
                    else begin
                        rk = K_DBL;
                        rb = int_to_double(kind == K_INT, mag);
                    end
                end else st = S_KIND;
            end
            default: st = S_NOTSCALAR;
        endcase
        if (st != S_OK) begin
            rk = K_NONE;
            rb = '0;
        end
        return {2'b00, st, rb, rk};
    endfunction

    function automatic logic [71:0] pack_literal(logic [2:0] kind, logic [63:0] bits,
                                                 logic [3:0] tgt);
        return {1'b0, tgt, bits, kind};
    endfunction

    // Values chosen to sit near the range edges of every target width.
    function automatic logic [63:0] edge_value();
        logic [63:0] base;
        case ($urandom_range(0, 9))
            0: base = 64'd0;
            1: base = 64'd1;
            2: base = 64'hFF;
            3: base = 64'hFFFF;
            4: base = 64'hFFFF_FFFF;
            5: base = 64'h7F;
            6: base = 64'h7FFF;
            7: base = 64'h7FFF_FFFF;
            8: base = SIGN_BIT;
            default: base = 64'd1 << $urandom_range(0, 63);
        endcase
        base = base + 64'($signed($urandom_range(0, 4)) - 2);
        return ($urandom_range(0, 1) != 0) ? 64'd0 - base : base;
    endfunction

    function automatic logic [63:0] random_bits();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return r;
            1: return edge_value();
            // Few set bits in a short span: exactly representable as float.
            2: return 64'($urandom_range(0, 24'hFF_FFFF)) << $urandom_range(0, 40);
            3: return 64'd0 - (64'($urandom_range(0, 24'hFF_FFFF)) << $urandom_range(0, 40));
            4: return 64'($urandom_range(0, 3));
            default: return r >> $urandom_range(0, 63);
        endcase
    endfunction

    // Driver: presents queued literals and holds each until it is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                coerced_q.push_back(coerce(s_axis_tdata));
                void'(literal_q.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 19) == 0) begin
                    src_gap <= $urandom_range(0, 15);
                    s_axis_tvalid <= 1'b0;
                end else if (literal_q.size() > 0) begin
                    // A taken entry has already left the queue; offer the front.
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= literal_q[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transaction against the oldest prediction
    // and drives a stalling ready.
    always @(posedge aclk) begin
        logic [71:0] want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (coerced_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction %h", m_axis_tdata);
                end else begin
                    want = coerced_q.pop_front();
                    if (want !== m_axis_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: kind %0d/%0d bits %h/%h status %0d/%0d",
                                     want[2:0], m_axis_tdata[2:0], want[66:3],
                                     m_axis_tdata[66:3], want[69:67], m_axis_tdata[69:67]);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                sink_gap <= $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Fills the literal queue for one phase under one setting of the switch, and
    // waits for the block to drain before each register write.
    task automatic run_phase(bit conv, int count);
        logic [2:0] kind;
        logic [3:0] tgt;
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= conv;
        @(posedge aclk);
        cfg_we <= 1'b0;
        conv_en = conv;
        // Directed part: every kind, including the unused codes, against a random
        // target, with extreme values.
        for (int k = 0; k < 8; k++) begin
            literal_q.push_back(pack_literal(3'(k), 64'hFFFF_FFFF_FFFF_FFFF,
                                             4'($urandom_range(0, 15))));
        end
        literal_q.push_back(pack_literal(K_INT, SIGN_BIT, T_LONG));
        literal_q.push_back(pack_literal(K_UINT, 64'hFFFF_FFFF_FFFF_FFFF, T_DOUBLE));
        literal_q.push_back(pack_literal(K_UINT, 64'd1, T_BOOLT));
        literal_q.push_back(pack_literal(K_UINT, 64'd2, T_BOOLT));
        literal_q.push_back(pack_literal(K_BOOL, 64'h10, T_UBYTE));
        literal_q.push_back(pack_literal(K_BOOL, 64'h0, T_BOOLT));
        literal_q.push_back(pack_literal(K_DBL, 64'h3FF0_0000_0000_0000, T_FLOAT));
        literal_q.push_back(pack_literal(K_DBL, 64'd5, T_INT));
        literal_q.push_back(pack_literal(K_INT, 64'd0 - 64'd129, T_BYTE));
        literal_q.push_back(pack_literal(K_INT, 64'h0, 4'd15));
        for (int i = 0; i < count; i++) begin
            kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            tgt = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                               : 4'($urandom_range(0, 11));
            literal_q.push_back(pack_literal(kind, random_bits(), tgt));
        end
        wait (literal_q.size() == 0 && coerced_q.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        run_phase(1'b0, 500);
        run_phase(1'b1, 500);
        run_phase(1'b0, 300);
        quiet = 1'b1;
        run_phase(1'b1, 300);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/slc_pkg.sv
rtl/slc_core.sv
rtl/scalar_literal_coercion.sv
rtl/slc_checker.sv
test/scalar_literal_coercion_tb.sv
